>>> rtl/bup_pkg.sv
// ----------------------------------------------------------------------------
// bup_pkg
// Types and constants shared by the bilinear upscaler.
// ----------------------------------------------------------------------------
package bup_pkg;

    localparam logic       ACT_LOAD    = 1'b0;
    localparam logic       ACT_QUERY   = 1'b1;

    localparam logic [1:0] CFG_ROWS    = 2'd0;
    localparam logic [1:0] CFG_COLS    = 2'd1;
    localparam logic [1:0] CFG_SCALE   = 2'd2;

    localparam logic [8:0] ROWS_RESET  = 9'd128;
    localparam logic [8:0] COLS_RESET  = 9'd128;
    localparam logic [4:0] SCALE_RESET = 5'd4;
    localparam logic [4:0] SCALE_LIMIT = 5'd16;

    typedef struct packed {
        logic        action;
        logic [7:0]  load_row;
        logic [7:0]  load_col;
        logic [7:0]  load_pixel;
        logic [11:0] query_row;
        logic [11:0] query_col;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_value;
        logic        range_error;
    } t_out_item;

endpackage

>>> rtl/bilinear_upscale_wrap_unit.sv
// ----------------------------------------------------------------------------
// bilinear_upscale_wrap_unit
// Bilinear upscaler over a stored 8-bit frame, neighbors wrap to index 0.
// ----------------------------------------------------------------------------
// One item is taken in every cycle (busy stays low). A load writes one pixel
// of the frame store and gives no result. A query gives its result on
// o_result for one cycle with o_result_valid, registered after stage 5; the
// receiver cannot stall. Division by the scale factor uses a reciprocal
// table and multipliers. The frame store is held twice so that the four
// neighbors are read in the same cycle, two ports on each copy. Loads and
// queries reach the store in the same stage, so a query sees every earlier
// load. No clearing pass: entries read before being loaded are undefined.
module bilinear_upscale_wrap_unit #(
    parameter int MAX_ROWS  = 256,
    parameter int MAX_COLS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  bup_pkg::t_in_item  i_item,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [8:0]         i_cfg_data,
    output logic               o_result_valid,
    output bup_pkg::t_out_item o_result
);
    import bup_pkg::*;

    localparam int RB  = $clog2(MAX_ROWS);
    localparam int CB  = $clog2(MAX_COLS);
    localparam int KB  = FRAC_BITS + 12;      // reciprocal fraction bits
    localparam int TW  = FRAC_BITS + 8;       // horizontal blend width
    localparam int VW  = 2 * FRAC_BITS + 8;   // full blend width
    localparam int SHR = (2 * FRAC_BITS >= 8) ? 2 * FRAC_BITS - 8 : 0;
    localparam int SHL = (2 * FRAC_BITS >= 8) ? 0 : 8 - 2 * FRAC_BITS;

    localparam logic [FRAC_BITS:0] WONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [KB:0]        RONE = {1'b1, {KB{1'b0}}};
    // ceil(2^KB / s) for s = 1..16
    localparam logic [KB:0] RECIP [16] = '{
        RONE,             (RONE + 1) / 2,   (RONE + 2) / 3,   (RONE + 3) / 4,
        (RONE + 4) / 5,   (RONE + 5) / 6,   (RONE + 6) / 7,   (RONE + 7) / 8,
        (RONE + 8) / 9,   (RONE + 9) / 10,  (RONE + 10) / 11, (RONE + 11) / 12,
        (RONE + 12) / 13, (RONE + 13) / 14, (RONE + 14) / 15, (RONE + 15) / 16
    };

    assign busy = 1'b0;

    // configuration
    logic [8:0] r_rows_cfg, r_cols_cfg;
    logic [4:0] r_scale_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg  <= ROWS_RESET;
            r_cols_cfg  <= COLS_RESET;
            r_scale_cfg <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ROWS:  r_rows_cfg  <= i_cfg_data;
                CFG_COLS:  r_cols_cfg  <= i_cfg_data;
                CFG_SCALE: r_scale_cfg <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    logic [8:0] w_rows, w_cols;
    logic [4:0] w_sc;

    always_comb begin
        w_rows = r_rows_cfg;
        if (r_rows_cfg == 9'd0) w_rows = 9'd1;
        else if (int'(r_rows_cfg) > MAX_ROWS) w_rows = 9'(MAX_ROWS);
        w_cols = r_cols_cfg;
        if (r_cols_cfg == 9'd0) w_cols = 9'd1;
        else if (int'(r_cols_cfg) > MAX_COLS) w_cols = 9'(MAX_COLS);
        w_sc = r_scale_cfg;
        if (r_scale_cfg == 5'd0) w_sc = 5'd1;
        else if (r_scale_cfg > SCALE_LIMIT) w_sc = SCALE_LIMIT;
    end

    // stage 1: range check, quotient by reciprocal
    logic        r_v1, r_act1;
    logic [7:0]  r_lrow1, r_lcol1, r_lpix1;
    logic [11:0] r_qr1, r_qc1;
    logic [8:0]  r_rows1, r_cols1;
    logic [4:0]  r_sc1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v1 <= 1'b0;
        else          r_v1 <= start && !busy;
        r_act1  <= i_item.action;
        r_lrow1 <= i_item.load_row;
        r_lcol1 <= i_item.load_col;
        r_lpix1 <= i_item.load_pixel;
        r_qr1   <= i_item.query_row;
        r_qc1   <= i_item.query_col;
        r_rows1 <= w_rows;
        r_cols1 <= w_cols;
        r_sc1   <= w_sc;
    end

    logic [13:0]      w_lim_r, w_lim_c;
    logic [KB:0]      w_rcp1;
    logic [KB+12:0]   w_pr, w_pc;
    logic             w_err1;

    assign w_lim_r = 14'(r_rows1 * r_sc1);
    assign w_lim_c = 14'(r_cols1 * r_sc1);
    assign w_err1  = ({2'b00, r_qr1} >= w_lim_r) || ({2'b00, r_qc1} >= w_lim_c);
    assign w_rcp1  = RECIP[4'(r_sc1 - 5'd1)];
    assign w_pr    = (KB+13)'(r_qr1) * (KB+13)'(w_rcp1);
    assign w_pc    = (KB+13)'(r_qc1) * (KB+13)'(w_rcp1);

    // stage 2: remainders and wrapped neighbors
    logic        r_v2, r_act2, r_err2;
    logic [7:0]  r_lrow2, r_lcol2, r_lpix2;
    logic [11:0] r_qr2, r_qc2, r_q_r2, r_q_c2;
    logic [8:0]  r_rows2, r_cols2;
    logic [4:0]  r_sc2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else          r_v2 <= r_v1;
        r_act2  <= r_act1;
        r_err2  <= w_err1;
        r_lrow2 <= r_lrow1;
        r_lcol2 <= r_lcol1;
        r_lpix2 <= r_lpix1;
        r_qr2   <= r_qr1;
        r_qc2   <= r_qc1;
        r_q_r2  <= 12'(w_pr >> KB);
        r_q_c2  <= 12'(w_pc >> KB);
        r_rows2 <= r_rows1;
        r_cols2 <= r_cols1;
        r_sc2   <= r_sc1;
    end

    logic [3:0]  w_rem_r, w_rem_c;
    logic [12:0] w_nr, w_nc, w_r1, w_c1;

    assign w_rem_r = 4'(r_qr2 - 12'(r_q_r2 * r_sc2));
    assign w_rem_c = 4'(r_qc2 - 12'(r_q_c2 * r_sc2));
    assign w_nr    = 13'(r_q_r2) + 13'd1;
    assign w_nc    = 13'(r_q_c2) + 13'd1;
    assign w_r1    = (w_nr >= 13'(r_rows2)) ? 13'd0 : w_nr;
    assign w_c1    = (w_nc >= 13'(r_cols2)) ? 13'd0 : w_nc;

    // stage 3: frame store access, fraction weights
    logic          r_v3, r_act3, r_err3;
    logic [7:0]    r_lrow3, r_lcol3, r_lpix3;
    logic [RB-1:0] r_r0_3, r_r1_3;
    logic [CB-1:0] r_c0_3, r_c1_3;
    logic [3:0]    r_rem_r3, r_rem_c3;
    logic [4:0]    r_sc3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v3 <= 1'b0;
        else          r_v3 <= r_v2;
        r_act3   <= r_act2;
        r_err3   <= r_err2;
        r_lrow3  <= r_lrow2;
        r_lcol3  <= r_lcol2;
        r_lpix3  <= r_lpix2;
        r_r0_3   <= RB'(r_q_r2);
        r_r1_3   <= RB'(w_r1);
        r_c0_3   <= CB'(r_q_c2);
        r_c1_3   <= CB'(w_c1);
        r_rem_r3 <= w_rem_r;
        r_rem_c3 <= w_rem_c;
        r_sc3    <= r_sc2;
    end

    logic [7:0] r_mem_top [MAX_ROWS][MAX_COLS];
    logic [7:0] r_mem_bot [MAX_ROWS][MAX_COLS];
    logic       w_wr;

    assign w_wr = r_v3 && (r_act3 == ACT_LOAD) &&
                  (int'(r_lrow3) < MAX_ROWS) && (int'(r_lcol3) < MAX_COLS);

    logic [7:0] r_tl, r_tr, r_bl, r_br;

    // both copies take every load; top copy serves row r0, bottom copy row r1
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem_top[RB'(r_lrow3)][CB'(r_lcol3)] <= r_lpix3;
            r_mem_bot[RB'(r_lrow3)][CB'(r_lcol3)] <= r_lpix3;
        end
        r_tl <= r_mem_top[r_r0_3][r_c0_3];
        r_tr <= r_mem_top[r_r0_3][r_c1_3];
        r_bl <= r_mem_bot[r_r1_3][r_c0_3];
        r_br <= r_mem_bot[r_r1_3][r_c1_3];
    end

    logic [KB:0]         w_rcp3;
    logic [KB+FRAC_BITS+5:0] w_wr_p, w_wc_p;

    assign w_rcp3 = RECIP[4'(r_sc3 - 5'd1)];
    assign w_wr_p = (KB+FRAC_BITS+6)'({r_rem_r3, {FRAC_BITS{1'b0}}}) *
                    (KB+FRAC_BITS+6)'(w_rcp3);
    assign w_wc_p = (KB+FRAC_BITS+6)'({r_rem_c3, {FRAC_BITS{1'b0}}}) *
                    (KB+FRAC_BITS+6)'(w_rcp3);

    // stage 4: horizontal blend
    logic                 r_v4, r_err4;
    logic [FRAC_BITS-1:0] r_fr4, r_fc4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v4 <= 1'b0;
        else          r_v4 <= r_v3 && (r_act3 == ACT_QUERY);
        r_err4 <= r_err3;
        r_fr4  <= FRAC_BITS'(w_wr_p >> KB);
        r_fc4  <= FRAC_BITS'(w_wc_p >> KB);
    end

    logic [FRAC_BITS:0] w_fc_inv;
    logic [TW:0]        w_top, w_bot;

    assign w_fc_inv = WONE - (FRAC_BITS+1)'(r_fc4);
    assign w_top = (TW+1)'(r_tl) * (TW+1)'(w_fc_inv) + (TW+1)'(r_tr) * (TW+1)'(r_fc4);
    assign w_bot = (TW+1)'(r_bl) * (TW+1)'(w_fc_inv) + (TW+1)'(r_br) * (TW+1)'(r_fc4);

    // stage 5: vertical blend
    logic                 r_v5, r_err5;
    logic [TW-1:0]        r_top5, r_bot5;
    logic [FRAC_BITS-1:0] r_fr5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v5 <= 1'b0;
        else          r_v5 <= r_v4;
        r_err5 <= r_err4;
        r_top5 <= w_top[TW-1:0];
        r_bot5 <= w_bot[TW-1:0];
        r_fr5  <= r_fr4;
    end

    logic [FRAC_BITS:0] w_fr_inv;
    logic [VW+8:0]      w_acc;
    logic [15:0]        w_val;

    assign w_fr_inv = WONE - (FRAC_BITS+1)'(r_fr5);
    assign w_acc = (VW+9)'(r_top5) * (VW+9)'(w_fr_inv) +
                   (VW+9)'(r_bot5) * (VW+9)'(r_fr5);
    assign w_val = 16'((w_acc >> SHR) << SHL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_result_valid <= 1'b0;
        else          o_result_valid <= r_v5;
        o_result.out_value   <= r_err5 ? 16'd0 : w_val;
        o_result.range_error <= r_err5;
    end

endmodule
